### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### rtl/core/qxmm_pkg.sv
// ----------------------------------------------------------------------------
// qxmm_pkg
// Formats, curve coefficients and payload types of the X-frame motor mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package qxmm_pkg;

   // Fixed-point formats.
   localparam int FRAC_BITS = 16;
   localparam int IN_W      = FRAC_BITS + 8;
   localparam int OUT_W     = FRAC_BITS + 7;
   localparam int MIX_BITS  = FRAC_BITS + 3;
   localparam int COEF_BITS = 24;

   // Mixed thrust holds up to 52 times a full-scale command.
   localparam int MIX_W = IN_W + 6;
   // Thrust inside the curve's working range (0, 20) is unsigned.
   localparam int F_W   = MIX_BITS + 5;

   // Datapath widths of the Horner evaluation.
   localparam int C3_W    = COEF_BITS - 5;
   localparam int M1_W    = C3_W + F_W;
   localparam int A_W     = COEF_BITS + 1;
   localparam int AF_W    = A_W + F_W + 1;
   localparam int B_W     = COEF_BITS + 5;
   localparam int BF_W    = B_W + F_W + 1;
   localparam int U_SHIFT = MIX_BITS + COEF_BITS - FRAC_BITS;
   localparam int U_W     = FRAC_BITS + 10;

   // Curve coefficients, rounded to nearest.
   localparam longint C1 = ((64'sd10833 << COEF_BITS) + 64'sd500) / 64'sd1000;
   localparam longint C2 = ((64'sd634836 << COEF_BITS) + 64'sd500000) / 64'sd1000000;
   localparam longint C3 = ((64'sd186263 << COEF_BITS) + 64'sd5000000) / 64'sd10000000;
   localparam longint C0 = ((64'sd66119 << FRAC_BITS) + 64'sd500000) / 64'sd1000000;

   // Rounding offsets for the two shift amounts.
   localparam longint HALF_MIX = 64'sd1 << (MIX_BITS - 1);
   localparam longint HALF_U   = 64'sd1 << (U_SHIFT - 1);

   // Limits.
   localparam longint LEVEL_MAX = 64'sd100 << FRAC_BITS;
   localparam longint F_HIGH    = 64'sd20 << MIX_BITS;

   // Pipeline shape.
   localparam int LANES  = 4;
   localparam int STAGES = 7;

   typedef struct packed {
      logic signed [IN_W-1:0] roll_cmd;
      logic signed [IN_W-1:0] pitch_cmd;
      logic signed [IN_W-1:0] yaw_cmd;
      logic signed [IN_W-1:0] thrust_cmd;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_W-1:0] motor0_level;
      logic [OUT_W-1:0] motor1_level;
      logic [OUT_W-1:0] motor2_level;
      logic [OUT_W-1:0] motor3_level;
   } rsp_payload_type;

endpackage

### rtl/core/quad_x_motor_mixer_cubic.sv
// ----------------------------------------------------------------------------
// quad_x_motor_mixer_cubic
// Mixes roll, pitch, yaw and thrust commands into four X-frame motor thrusts,
// maps each through a cubic thrust-to-command curve and clamps to 0..100.
// ----------------------------------------------------------------------------
// Each accepted command set moves through the stage registers in order, and
// its result is valid in the last one. Throughput: one command set per cycle
// unless the output stalls; seven register stages, in which adder stages
// alternate with one multiplier per motor lane; a stage refills on a bubble.
// Reset clears only the stage valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quad_x_motor_mixer_cubic
   import qxmm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam logic signed [MIX_W-1:0] F_HIGH_S   = MIX_W'(F_HIGH);
   localparam logic        [C3_W-1:0]  C3_U       = C3_W'(C3);
   localparam logic signed [A_W-1:0]   C2_S       = A_W'(C2);
   localparam logic signed [B_W-1:0]   C1_S       = B_W'(C1);
   localparam logic signed [U_W-1:0]   C0_S       = U_W'(C0);
   localparam logic signed [U_W-1:0]   LEVEL_MAX_S = U_W'(LEVEL_MAX);
   localparam logic        [OUT_W-1:0] LEVEL_MAX_U = OUT_W'(LEVEL_MAX);

   // Stage control.
   logic [STAGES:1] valid_ff;
   logic [STAGES:1] valid_in;
   logic [STAGES:1] adv;

   // Per-lane pipeline registers.
   logic        [F_W-1:0]   f_ff    [1:5][LANES];
   logic        [F_W-1:0]   f_in    [1:5][LANES];
   logic        [LANES-1:0] lo_ff   [1:6];
   logic        [LANES-1:0] lo_in   [1:6];
   logic        [LANES-1:0] hi_ff   [1:6];
   logic        [LANES-1:0] hi_in   [1:6];
   logic        [M1_W-1:0]  m1_ff   [LANES];
   logic        [M1_W-1:0]  m1_in   [LANES];
   logic signed [A_W-1:0]   a_ff    [LANES];
   logic signed [A_W-1:0]   a_in    [LANES];
   logic signed [AF_W-1:0]  af_ff   [LANES];
   logic signed [AF_W-1:0]  af_in   [LANES];
   logic signed [B_W-1:0]   b_ff    [LANES];
   logic signed [B_W-1:0]   b_in    [LANES];
   logic signed [BF_W-1:0]  bf_ff   [LANES];
   logic signed [BF_W-1:0]  bf_in   [LANES];
   logic        [OUT_W-1:0] level_ff[LANES];
   logic        [OUT_W-1:0] level_in[LANES];

   // Combinational temporaries.
   logic signed [MIX_W-1:0] r_x, p_x, y_x, t_x;
   logic signed [MIX_W-1:0] r5, p5, y40, t2;
   logic signed [MIX_W-1:0] mix    [LANES];
   logic        [M1_W:0]    m1r    [LANES];
   logic signed [AF_W-1:0]  afr    [LANES];
   logic signed [AF_W-1:0]  afs    [LANES];
   logic signed [BF_W-1:0]  bfr    [LANES];
   logic signed [BF_W-1:0]  bfs    [LANES];
   logic signed [U_W-1:0]   u_val  [LANES];

   // A stage advances when it is empty or the stage after it advances.
   always_comb begin
      adv[STAGES] = !valid_ff[STAGES] || rsp_ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[1] = req_valid;
      for (int k = 2; k <= STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Stage 1: mix the commands with the X-frame sign pattern, in Q.(FRAC+3).
   always_comb begin
      r_x = MIX_W'(req_data.roll_cmd);
      p_x = MIX_W'(req_data.pitch_cmd);
      y_x = MIX_W'(req_data.yaw_cmd);
      t_x = MIX_W'(req_data.thrust_cmd);
      r5  = (r_x <<< 2) + r_x;
      p5  = (p_x <<< 2) + p_x;
      y40 = (y_x <<< 5) + (y_x <<< 3);
      t2  = t_x <<< 1;
      mix[0] =  r5 - p5 - y40 + t2;
      mix[1] = -r5 - p5 + y40 + t2;
      mix[2] = -r5 + p5 - y40 + t2;
      mix[3] =  r5 + p5 + y40 + t2;
      for (int i = 0; i < LANES; i++) begin
         f_in[1][i] = mix[i][F_W-1:0];
         lo_in[1][i] = mix[i][MIX_W-1] || (mix[i] == '0);
         hi_in[1][i] = (mix[i] >= F_HIGH_S);
      end

      // Thrust and range flags travel alongside the Horner terms.
      for (int k = 2; k <= 5; k++) begin
         for (int i = 0; i < LANES; i++) begin
            f_in[k][i] = f_ff[k-1][i];
         end
      end
      for (int k = 2; k <= 6; k++) begin
         lo_in[k] = lo_ff[k-1];
         hi_in[k] = hi_ff[k-1];
      end
   end

   // Stages 2 to 7: Horner evaluation of the cubic, one step per stage.
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         // Stage 2: c3 * F.
         m1_in[i] = C3_U * f_ff[1][i];

         // Stage 3: a = rnd(c3 * F) - c2.
         m1r[i]  = {1'b0, m1_ff[i]} + (M1_W + 1)'(HALF_MIX);
         a_in[i] = signed'({1'b0, m1r[i][MIX_BITS+A_W-2:MIX_BITS]}) - C2_S;

         // Stage 4: a * F.
         af_in[i] = a_ff[i] * signed'({1'b0, f_ff[3][i]});

         // Stage 5: b = rnd(a * F) + c1.
         afr[i]  = af_ff[i] + AF_W'(HALF_MIX);
         afs[i]  = afr[i] >>> MIX_BITS;
         b_in[i] = signed'(afs[i][B_W-1:0]) + C1_S;

         // Stage 6: b * F.
         bf_in[i] = b_ff[i] * signed'({1'b0, f_ff[5][i]});

         // Stage 7: u = rnd(b * F) - c0, then saturate and clamp.
         bfr[i]   = bf_ff[i] + BF_W'(HALF_U);
         bfs[i]   = bfr[i] >>> U_SHIFT;
         u_val[i] = signed'(bfs[i][U_W-1:0]) - C0_S;
         if (lo_ff[6][i]) begin
            level_in[i] = '0;
         end else if (hi_ff[6][i]) begin
            level_in[i] = LEVEL_MAX_U;
         end else if (u_val[i] < 0) begin
            level_in[i] = '0;
         end else if (u_val[i] > LEVEL_MAX_S) begin
            level_in[i] = LEVEL_MAX_U;
         end else begin
            level_in[i] = u_val[i][OUT_W-1:0];
         end
      end
   end

   // Payload registers load when their stage advances.
   always_ff @(posedge clock) begin
      for (int k = 1; k <= 5; k++) begin
         if (adv[k]) begin
            f_ff[k] <= f_in[k];
         end
      end
      for (int k = 1; k <= 6; k++) begin
         if (adv[k]) begin
            lo_ff[k] <= lo_in[k];
            hi_ff[k] <= hi_in[k];
         end
      end
      if (adv[2]) begin
         m1_ff <= m1_in;
      end
      if (adv[3]) begin
         a_ff <= a_in;
      end
      if (adv[4]) begin
         af_ff <= af_in;
      end
      if (adv[5]) begin
         b_ff <= b_in;
      end
      if (adv[6]) begin
         bf_ff <= bf_in;
      end
      if (adv[7]) begin
         level_ff <= level_in;
      end
   end

   // Result transfer.
   assign rsp_valid             = valid_ff[STAGES];
   assign rsp_data.motor0_level = level_ff[0];
   assign rsp_data.motor1_level = level_ff[1];
   assign rsp_data.motor2_level = level_ff[2];
   assign rsp_data.motor3_level = level_ff[3];

   // Checks.
   `ASSERT_IMPLIES(a_level_range, clock, reset, rsp_valid,
      (rsp_data.motor0_level <= LEVEL_MAX_U) && (rsp_data.motor1_level <= LEVEL_MAX_U) &&
      (rsp_data.motor2_level <= LEVEL_MAX_U) && (rsp_data.motor3_level <= LEVEL_MAX_U),
      "motor level above full scale")
   `ASSERT_IMPLIES(a_flags_exclusive, clock, reset, valid_ff[1],
      (lo_ff[1] & hi_ff[1]) == '0, "thrust flagged both low and high")
   `ASSERT_NEXT(a_stall_holds, clock, reset, valid_ff[STAGES] && !rsp_ready,
      valid_ff[STAGES], "stalled result dropped")
   `ASSERT_IMPLIES(a_full_when_blocked, clock, reset, !req_ready,
      valid_ff == '1, "input blocked while pipeline has a bubble")

endmodule

### test/tb_quad_x_motor_mixer_cubic.sv
// ----------------------------------------------------------------------------
// tb_quad_x_motor_mixer_cubic
// Self-checking bench for the X-frame motor mixer. Command sets are sent over
// the request channel. A scoreboard predicts the four clamped motor levels of
// each accepted command and checks the response transfers in order. The run
// covers field extremes, the saturation and clamp edges of the curve, and
// random hover-like commands. Both channels idle at random in several phases,
// and one long response stall fills the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quad_x_motor_mixer_cubic;
   import qxmm_pkg::*;

   // Mixed thrust is exact in Q.(FRAC_BITS+3); curve gains are Q.24.
   localparam int     THRUST_Q     = FRAC_BITS + 3;
   localparam int     GAIN_Q       = 24;
   localparam int     LEVEL_SHIFT  = THRUST_Q + GAIN_Q - FRAC_BITS;
   localparam longint LIN_GAIN     = ((64'sd10833 << GAIN_Q) + 64'sd500) / 64'sd1000;
   localparam longint SQR_GAIN     = ((64'sd634836 << GAIN_Q) + 64'sd500000) / 64'sd1000000;
   localparam longint CUBE_GAIN    = ((64'sd186263 << GAIN_Q) + 64'sd5000000)
                                     / 64'sd10000000;
   localparam longint CURVE_OFFSET = ((64'sd66119 << FRAC_BITS) + 64'sd500000)
                                     / 64'sd1000000;
   localparam longint THRUST_HALF  = 64'sd1 << (THRUST_Q - 1);
   localparam longint LEVEL_HALF   = 64'sd1 << (LEVEL_SHIFT - 1);
   localparam longint LEVEL_FULL   = 64'sd100 << FRAC_BITS;
   localparam longint THRUST_SAT   = 64'sd20 << THRUST_Q;

   // Command limits and one unit in the command format.
   localparam int CMD_MAX = (1 << (IN_W - 1)) - 1;
   localparam int CMD_MIN = -(1 << (IN_W - 1));
   localparam int UNIT    = 1 << FRAC_BITS;

   localparam int PHASE_ITEMS = 225;
   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 20;

   // Scoreboard: predicts motor levels and checks responses in order.
   class mixer_scoreboard;
      rsp_payload_type pending_levels[$];
      int              mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Cubic thrust-to-command curve with saturation and clamp.
      function logic [OUT_W-1:0] motor_level(longint thrust);
         longint quad;
         longint lin;
         longint level;
         if (thrust <= 0) return '0;
         if (thrust >= THRUST_SAT) return OUT_W'(LEVEL_FULL);
         quad  = ((CUBE_GAIN * thrust + THRUST_HALF) >>> THRUST_Q) - SQR_GAIN;
         lin   = ((quad * thrust + THRUST_HALF) >>> THRUST_Q) + LIN_GAIN;
         level = ((lin * thrust + LEVEL_HALF) >>> LEVEL_SHIFT) - CURVE_OFFSET;
         if (level < 0) level = 0;
         else if (level > LEVEL_FULL) level = LEVEL_FULL;
         return level[OUT_W-1:0];
      endfunction

      // X-frame mixing: roll and pitch 0.625, yaw 5, thrust 0.25.
      function rsp_payload_type mix_levels(req_payload_type cmd);
         longint r;
         longint p;
         longint y;
         longint t;
         rsp_payload_type lv;
         r = $signed(cmd.roll_cmd);
         p = $signed(cmd.pitch_cmd);
         y = $signed(cmd.yaw_cmd);
         t = $signed(cmd.thrust_cmd);
         lv.motor0_level = motor_level( 5 * r - 5 * p - 40 * y + 2 * t);
         lv.motor1_level = motor_level(-5 * r - 5 * p + 40 * y + 2 * t);
         lv.motor2_level = motor_level(-5 * r + 5 * p - 40 * y + 2 * t);
         lv.motor3_level = motor_level( 5 * r + 5 * p + 40 * y + 2 * t);
         return lv;
      endfunction

      function void note_command(req_payload_type cmd);
         pending_levels.insert(pending_levels.size(), mix_levels(cmd));
      endfunction

      function int pending();
         return pending_levels.size();
      endfunction

      function void compare_level(string field, logic [OUT_W-1:0] want,
                                  logic [OUT_W-1:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: %s expected %0d got %0d", field, want, got);
         end
      endfunction

      function void check_levels(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_levels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response transfer with no command pending");
            return;
         end
         want = pending_levels.pop_front();
         compare_level("motor0_level", want.motor0_level, got.motor0_level);
         compare_level("motor1_level", want.motor1_level, got.motor1_level);
         compare_level("motor2_level", want.motor2_level, got.motor2_level);
         compare_level("motor3_level", want.motor3_level, got.motor3_level);
      endfunction
   endclass

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   mixer_scoreboard sb = new();
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              hold_request   = 0;

   quad_x_motor_mixer_cubic dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic req_payload_type make_command(int r, int p, int y, int t);
      req_payload_type cmd;
      cmd.roll_cmd   = IN_W'(r);
      cmd.pitch_cmd  = IN_W'(p);
      cmd.yaw_cmd    = IN_W'(y);
      cmd.thrust_cmd = IN_W'(t);
      return cmd;
   endfunction

   // Mostly hover-like commands with moderate roll, pitch and yaw, some small
   // commands near zero thrust, and some noise.
   function automatic req_payload_type random_command();
      req_payload_type cmd;
      int unsigned     pick;
      pick = $urandom_range(99);
      if (pick < 20) begin
         cmd = {$urandom(), $urandom(), $urandom()};
      end else if (pick < 80) begin
         cmd.roll_cmd   = IN_W'($urandom_range(16 * UNIT) - 8 * UNIT);
         cmd.pitch_cmd  = IN_W'($urandom_range(16 * UNIT) - 8 * UNIT);
         cmd.yaw_cmd    = IN_W'($urandom_range(2 * UNIT) - UNIT);
         cmd.thrust_cmd = IN_W'($urandom_range(80 * UNIT));
      end else begin
         cmd.roll_cmd   = IN_W'($urandom_range(4 * UNIT) - 2 * UNIT);
         cmd.pitch_cmd  = IN_W'($urandom_range(4 * UNIT) - 2 * UNIT);
         cmd.yaw_cmd    = IN_W'($urandom_range(UNIT) - UNIT / 2);
         cmd.thrust_cmd = IN_W'($urandom_range(8 * UNIT) - 4 * UNIT);
      end
      return cmd;
   endfunction

   // Offers one command, after any random idle gap, and waits for its transfer.
   task automatic send_command(input req_payload_type cmd);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      do @(posedge clock); while (!req_ready);
      sb.note_command(cmd);
   endtask

   // Response side: checks each transfer and drives ready, with random
   // stalls and the one long hold-off, counted here.
   initial begin : response_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_levels(rsp_data);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Stimulus: corner cases, then random phases with different idling.
   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Field extremes and each motor's extreme thrust.
      send_command(make_command(0, 0, 0, 0));
      send_command(make_command(CMD_MAX, CMD_MAX, CMD_MAX, CMD_MAX));
      send_command(make_command(CMD_MIN, CMD_MIN, CMD_MIN, CMD_MIN));
      send_command(make_command(CMD_MAX, 0, 0, 0));
      send_command(make_command(CMD_MIN, 0, 0, 0));
      send_command(make_command(0, CMD_MAX, 0, 0));
      send_command(make_command(0, CMD_MIN, 0, 0));
      send_command(make_command(0, 0, CMD_MAX, 0));
      send_command(make_command(0, 0, CMD_MIN, 0));
      send_command(make_command(0, 0, 0, CMD_MAX));
      send_command(make_command(0, 0, 0, CMD_MIN));
      send_command(make_command(CMD_MAX, CMD_MIN, CMD_MIN, CMD_MAX));
      send_command(make_command(CMD_MIN, CMD_MAX, CMD_MAX, CMD_MIN));
      // Smallest positive thrust on motors 0 and 3.
      send_command(make_command(1, 0, 0, -2));
      // Thrust exactly at, two below and one below the saturation point.
      send_command(make_command(0, 0, 0, 80 * UNIT));
      send_command(make_command(0, 0, 0, 80 * UNIT - 1));
      send_command(make_command(1, 0, 0, 80 * UNIT - 3));
      // Just below and just above the curve's zero crossing, where the low clamp acts.
      send_command(make_command(0, 0, 0, 1600));
      send_command(make_command(0, 0, 0, 1700));
      // Hover, and around the curve's crossing of full scale.
      send_command(make_command(0, 0, 0, 40 * UNIT));
      send_command(make_command(0, 0, 0, 73 * UNIT));
      send_command(make_command(0, 0, 0, 74 * UNIT));
      send_command(make_command(2 * UNIT, -3 * UNIT, UNIT / 4, 50 * UNIT));
      send_command(make_command(0, 0, UNIT / 2, 40 * UNIT));

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               // Long response stall while commands keep coming.
               hold_request   = LONG_HOLD;
            end
            1: begin
               send_idle_pct  = 63;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 63;
            end
            default: begin
               send_idle_pct  = 13;
               recv_stall_pct = 13;
            end
         endcase
         repeat (PHASE_ITEMS) send_command(random_command());
      end
      req_valid <= 1'b0;

      // Drain the pipeline, then let any stray responses show up.
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb_quad_x_motor_mixer_cubic passed");
      end else begin
         $display("tb_quad_x_motor_mixer_cubic failed");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin : watchdog
      #2000000;
      $display("tb_quad_x_motor_mixer_cubic failed");
      $finish;
   end

endmodule
